>>> rtl/plist_pkg.sv
// shared types, constants and helpers for the positional list store
// no dependencies
`timescale 1ns / 1ps

package plist_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 8;
    localparam int LEN_W    = 7;
    localparam int DATA_W   = 32;
    localparam int PCMP_W   = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    localparam logic [2:0] MODE_CLEAR  = 3'd0;
    localparam logic [2:0] MODE_INSERT = 3'd1;
    localparam logic [2:0] MODE_DELETE = 3'd2;
    localparam logic [2:0] MODE_GET    = 3'd3;
    localparam logic [2:0] MODE_LOCATE = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_WRITE,
        ST_FILL,
        ST_GET,
        ST_CMP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [2:0]              mode;
        logic [POS_W-1:0]        position;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic                     ok;
        logic signed [DATA_W-1:0] read_value;
        logic [LEN_W-1:0]         found_position;
        logic [LEN_W-1:0]         length;
    } rsp_t;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        logic [DATA_W-1:0] data;
    } mem_wr_t;

    function automatic logic [LEN_W-1:0] to_len(input logic [CNT_W-1:0] c);
        logic [CNT_W+LEN_W-1:0] w;
        w = {{LEN_W{1'b0}}, c};
        return w[LEN_W-1:0];
    endfunction

endpackage

>>> rtl/plist_store.sv
// element memory: one write port, one registered read port
// depends on plist_pkg
`timescale 1ns / 1ps

module plist_store (
    input  logic                     clk,
    input  plist_pkg::mem_wr_t       wr,
    input  logic [plist_pkg::IDX_W-1:0]  raddr,
    output logic [plist_pkg::DATA_W-1:0] rdata
);
    import plist_pkg::*;

    logic [DATA_W-1:0] mem [CAPACITY];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/plist_ctrl.sv
// sequencer for the list operations: shifts, reads and searches one entry per step
// depends on plist_pkg and plist_store
`timescale 1ns / 1ps

module plist_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  plist_pkg::req_t req,
    output logic            res_valid,
    input  logic            res_take,
    output plist_pkg::rsp_t res
);
    import plist_pkg::*;

    state_t state_reg, state_next;
    logic [2:0]        op_reg, op_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  bound_reg, bound_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              ok_reg, ok_next;
    logic [DATA_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0]  fp_reg, fp_next;

    logic [POS_W-1:0]  p_eff;
    logic [PCMP_W-1:0] p_ext;
    logic [PCMP_W-1:0] cnt_ext;
    logic [IDX_W-1:0]  p_idx;
    logic              ins_ok;
    logic              pos_ok;
    logic              at_bound;
    logic [IDX_W-1:0]  idx_step;
    logic              hit;
    logic              accept;

    mem_wr_t           wr;
    logic [IDX_W-1:0]  raddr;
    logic [DATA_W-1:0] rdata;

    plist_store u_store (
        .clk   (clk),
        .wr    (wr),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign p_eff   = (req.position == '0) ? POS_W'(1) : req.position;
    assign p_ext   = PCMP_W'(p_eff);
    assign cnt_ext = PCMP_W'(count_reg);
    assign p_idx   = IDX_W'(p_eff - POS_W'(1));
    assign ins_ok  = (p_ext <= cnt_ext + PCMP_W'(1)) && (count_reg < CNT_W'(CAPACITY));
    assign pos_ok  = (p_ext <= cnt_ext);
    assign accept  = req_valid && req_ready;

    // shared index unit
    assign at_bound = (CNT_W'(idx_reg) == bound_reg);
    assign idx_step = (op_reg == MODE_INSERT) ? idx_reg - IDX_W'(1) : idx_reg + IDX_W'(1);
    assign hit      = (rdata == val_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    case (req.mode)
                        MODE_INSERT:
                        begin
                            if (!ins_ok)
                                state_next = ST_DONE;
                            else if (IDX_W'(count_reg) == p_idx)
                                state_next = ST_FILL;
                            else
                                state_next = ST_READ;
                        end
                        MODE_DELETE:
                        begin
                            if (pos_ok && (CNT_W'(p_eff) != count_reg))
                                state_next = ST_READ;
                            else
                                state_next = ST_DONE;
                        end
                        MODE_GET:
                            state_next = pos_ok ? ST_READ : ST_DONE;
                        MODE_LOCATE:
                            state_next = (count_reg != '0) ? ST_READ : ST_DONE;
                        default:
                            state_next = ST_DONE;
                    endcase
                end
            end
            ST_READ:
            begin
                case (op_reg)
                    MODE_GET:    state_next = ST_GET;
                    MODE_LOCATE: state_next = ST_CMP;
                    default:     state_next = ST_WRITE;
                endcase
            end
            ST_WRITE:
            begin
                if (at_bound)
                    state_next = (op_reg == MODE_INSERT) ? ST_FILL : ST_DONE;
                else
                    state_next = ST_READ;
            end
            ST_FILL:
                state_next = ST_DONE;
            ST_GET:
                state_next = ST_DONE;
            ST_CMP:
                state_next = (hit || at_bound) ? ST_DONE : ST_READ;
            ST_DONE:
                state_next = res_take ? ST_IDLE : ST_DONE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        req_ready = (state_reg == ST_IDLE);
        res_valid = (state_reg == ST_DONE);
        raddr     = ((op_reg == MODE_INSERT) || (op_reg == MODE_DELETE)) ? idx_step : idx_reg;
        wr.en     = (state_reg == ST_WRITE) || (state_reg == ST_FILL);
        wr.addr   = idx_reg;
        wr.data   = (state_reg == ST_FILL) ? val_reg : rdata;
    end

    // datapath
    always_comb
    begin
        op_next    = op_reg;
        val_next   = val_reg;
        idx_next   = idx_reg;
        bound_next = bound_reg;
        count_next = count_reg;
        ok_next    = ok_reg;
        rd_next    = rd_reg;
        fp_next    = fp_reg;
        if (accept)
        begin
            op_next  = req.mode;
            val_next = req.value;
            ok_next  = 1'b0;
            rd_next  = '0;
            fp_next  = '0;
            case (req.mode)
                MODE_CLEAR:
                begin
                    count_next = '0;
                    ok_next    = 1'b1;
                end
                MODE_INSERT:
                begin
                    idx_next   = IDX_W'(count_reg);
                    bound_next = CNT_W'(p_idx) + CNT_W'(1);
                    if (ins_ok && (IDX_W'(count_reg) == p_idx))
                        idx_next = p_idx;
                end
                MODE_DELETE:
                begin
                    idx_next   = p_idx;
                    bound_next = count_reg - CNT_W'(2);
                    if (pos_ok && (CNT_W'(p_eff) == count_reg))
                    begin
                        count_next = count_reg - CNT_W'(1);
                        ok_next    = 1'b1;
                    end
                end
                MODE_GET:
                    idx_next = p_idx;
                MODE_LOCATE:
                begin
                    idx_next   = '0;
                    bound_next = count_reg - CNT_W'(1);
                end
                default:
                    ok_next = 1'b0;
            endcase
        end
        else
        begin
            case (state_reg)
                ST_WRITE:
                begin
                    idx_next = idx_step;
                    if (at_bound && (op_reg == MODE_DELETE))
                    begin
                        count_next = count_reg - CNT_W'(1);
                        ok_next    = 1'b1;
                    end
                end
                ST_FILL:
                begin
                    count_next = count_reg + CNT_W'(1);
                    ok_next    = 1'b1;
                end
                ST_GET:
                begin
                    rd_next = rdata;
                    ok_next = 1'b1;
                end
                ST_CMP:
                begin
                    if (hit)
                    begin
                        ok_next = 1'b1;
                        fp_next = CNT_W'(idx_reg) + CNT_W'(1);
                    end
                    else
                        idx_next = idx_step;
                end
                default:
                    idx_next = idx_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        val_reg   <= val_next;
        idx_reg   <= idx_next;
        bound_reg <= bound_next;
        ok_reg    <= ok_next;
        rd_reg    <= rd_next;
        fp_reg    <= fp_next;
    end

    assign res.ok             = ok_reg;
    assign res.read_value     = rd_reg;
    assign res.found_position = to_len(fp_reg);
    assign res.length         = to_len(count_reg);

endmodule

>>> rtl/positional_list_store_top.sv
// top level of the positional list store: sequencer plus result register
// depends on plist_pkg and plist_ctrl
`timescale 1ns / 1ps

// Ordered list of up to 64 signed 32-bit values with clear, insert, delete,
// get and locate by 1-based position. One request is in work at a time; a
// single sequencer steps through the element memory one entry at a time (a
// registered read, then a write or compare), so the time taken follows the
// work done: clear, a rejected request or an unused mode goes straight to
// the result, get reads one entry, insert at p moves entries p to count up
// by one and writes p, delete moves the entries after p down by one, and
// locate compares from the first entry to a hit or the last. The result sits
// in an output register, so the next request is taken while an earlier result
// still waits. Entries never written are never read: no clearing after reset.
module positional_list_store_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  plist_pkg::req_t req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output plist_pkg::rsp_t rsp
);
    import plist_pkg::*;

    logic res_valid;
    logic res_take;
    rsp_t res;

    logic out_valid_reg, out_valid_next;
    rsp_t rsp_reg;

    plist_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res)
    );

    assign res_take       = res_valid && (!out_valid_reg || rsp_ready);
    assign out_valid_next = res_take || (out_valid_reg && !rsp_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = rsp_reg;

endmodule
